// ===== design/chme_pkg.sv =====
`default_nettype none
package chme_pkg;
  localparam int unsigned Buckets        = 61;
  localparam int unsigned NodesDefault   = 64;

  typedef enum logic [1:0] {
    CmdInsert = 2'd0,
    CmdErase  = 2'd1,
    CmdLookup = 2'd2,
    CmdNone   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    StDone   = 2'd0,
    StAbsent = 2'd1,
    StFull   = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    SIdle,
    SMod,
    SFold,
    SHeadRd,
    SHeadWait,
    SNodeWait,
    SCheck,
    SFreeWait,
    SInsWr,
    SEraseRd,
    SEraseWait,
    SEraseWr,
    SValWait,
    SOut,
    SInit
  } state_e;
endpackage
`default_nettype wire

// ===== design/chained_hash_map_engine.sv =====
`default_nettype none
// Key/value map with separate chaining over a fixed pool of NODES nodes and
// 61 buckets. One command per input beat (insert, erase, lookup), one result
// beat each. After reset a clearing pass sets every bucket head to null and
// chains the free list; no command is taken meanwhile. The bucket index is
// the key mod 61, reduced in the SMod and SFold states by folding the key's
// 6-bit digits (64 is 3 mod 61). The chain is then walked node by node from
// the bucket head; an insert that takes a node goes on through SFreeWait and
// SInsWr, an erase at the chain head through SEraseWr and one further down
// the chain through SEraseWr and SEraseRd. The next command is taken the
// cycle after the result beat leaves, so chain length sets the rate. Heads,
// keys, values and links sit in synchronous memories with registered reads.
module chained_hash_map_engine #(
  parameter int unsigned NODES   = chme_pkg::NodesDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  command_i,
  input  wire logic [31:0] key_i,
  input  wire logic [31:0] payload_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       status_o,
  output logic [31:0]      found_value_o,
  output logic [6:0]       entry_count_o
);
  localparam int unsigned BUCKETS = chme_pkg::Buckets;
  localparam int unsigned LW = $clog2(NODES + 1);
  localparam int unsigned BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned NW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int unsigned IW = $clog2(((BUCKETS > NODES) ? BUCKETS : NODES) + 1);
  localparam logic [LW-1:0] LinkNull = LW'(NODES);
  localparam int unsigned InitLast = ((BUCKETS > NODES) ? BUCKETS : NODES) - 1;
  // weights of the key's 6-bit digits mod the bucket count
  localparam int unsigned Pow1Mod = 64 % BUCKETS;
  localparam int unsigned Pow2Mod = (1 << 12) % BUCKETS;
  localparam int unsigned Pow3Mod = (1 << 18) % BUCKETS;
  localparam int unsigned Pow4Mod = (1 << 24) % BUCKETS;
  localparam int unsigned Pow5Mod = (1 << 30) % BUCKETS;

  logic [LW-1:0] head_mem [BUCKETS];
  logic [31:0]   key_mem  [NODES];
  logic [31:0]   val_mem  [NODES];
  logic [LW-1:0] link_mem [NODES];

  chme_pkg::state_e state_q, state_d;
  logic [1:0]    cmd_q;
  logic [31:0]   key_q, pay_q;
  logic [BW-1:0] rem_q, rem_d;
  logic [11:0]   fold_q, fold_d;
  logic [LW-1:0] cur_q, cur_d, prev_q, prev_d, free_q, free_d, nlink_q, nlink_d;
  logic [LW-1:0] headv_q;
  logic [IW-1:0] steps_q, steps_d, init_q, init_d;
  logic [6:0]    cnt_q, cnt_d;
  logic [1:0]    st_q, st_d;
  logic [31:0]   fv_q, fv_d;
  logic          ov_q, ov_d;

  logic [LW-1:0] head_rd, link_rd;
  logic [31:0]   key_rd, val_rd;
  logic          head_we, link_we, node_we;
  logic [BW-1:0] head_wa;
  logic [LW-1:0] head_wd, link_wd;
  logic [NW-1:0] link_a, node_a;
  logic          head_re;
  logic [7:0]    fold1;
  logic [6:0]    fold2;
  logic          cur_ok;

  assign cur_ok = cur_q < LinkNull;
  assign fold1 = 8'(fold_q[11:6]) * 8'(Pow1Mod) + 8'(fold_q[5:0]);
  assign fold2 = 7'(fold1[7:6]) * 7'(Pow1Mod) + 7'(fold1[5:0]);

  always_ff @(posedge clk_i) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    if (head_re) head_rd <= head_mem[rem_q];
    if (link_we) link_mem[link_a] <= link_wd;
    link_rd <= link_mem[link_a];
    if (node_we) begin
      key_mem[node_a] <= key_q;
      val_mem[node_a] <= pay_q;
    end
    key_rd <= key_mem[node_a];
    val_rd <= val_mem[node_a];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= chme_pkg::SInit;
      init_q  <= '0;
      free_q  <= '0;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      init_q  <= init_d;
      free_q  <= free_d;
      cnt_q   <= cnt_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q <= command_i;
      key_q <= key_i;
      pay_q <= payload_i;
    end
    rem_q   <= rem_d;
    fold_q  <= fold_d;
    cur_q   <= cur_d;
    prev_q  <= prev_d;
    nlink_q <= nlink_d;
    steps_q <= steps_d;
    st_q    <= st_d;
    fv_q    <= fv_d;
    if (state_q == chme_pkg::SHeadWait) headv_q <= head_rd;
  end

  always_comb begin
    state_d = state_q;
    init_d = init_q;
    rem_d = rem_q;
    fold_d = fold_q;
    cur_d = cur_q;
    prev_d = prev_q;
    nlink_d = nlink_q;
    free_d = free_q;
    steps_d = steps_q;
    cnt_d = cnt_q;
    st_d = st_q;
    fv_d = fv_q;
    ov_d = ov_q;
    head_we = 1'b0;
    head_re = 1'b0;
    head_wa = rem_q;
    head_wd = LinkNull;
    link_we = 1'b0;
    link_wd = LinkNull;
    link_a = cur_q[NW-1:0];
    node_we = 1'b0;
    node_a = cur_q[NW-1:0];
    in_ready_o = 1'b0;
    if (ov_q && out_ready_i) ov_d = 1'b0;
    unique case (state_q)
      chme_pkg::SInit: begin
        if (init_q < IW'(BUCKETS)) begin
          head_we = 1'b1;
          head_wa = init_q[BW-1:0];
        end
        if (init_q < IW'(NODES)) begin
          link_we = 1'b1;
          link_a = init_q[NW-1:0];
          link_wd = LW'(init_q + 1'b1);
        end
        init_d = init_q + 1'b1;
        if (init_q == IW'(InitLast)) state_d = chme_pkg::SIdle;
      end
      chme_pkg::SIdle: begin
        in_ready_o = !ov_q;
        if (in_valid_i && !ov_q) begin
          st_d = chme_pkg::StAbsent;
          fv_d = '0;
          steps_d = '0;
          prev_d = LinkNull;
          state_d = chme_pkg::SMod;
        end
      end
      chme_pkg::SMod: begin
        fold_d = 12'(key_q[5:0]) + 12'(key_q[11:6]) * 12'(Pow1Mod)
               + 12'(key_q[17:12]) * 12'(Pow2Mod) + 12'(key_q[23:18]) * 12'(Pow3Mod)
               + 12'(key_q[29:24]) * 12'(Pow4Mod) + 12'(key_q[31:30]) * 12'(Pow5Mod);
        state_d = chme_pkg::SFold;
      end
      chme_pkg::SFold: begin
        if (fold2 >= 7'(BUCKETS)) rem_d = BW'(fold2 - 7'(BUCKETS));
        else rem_d = BW'(fold2);
        state_d = chme_pkg::SHeadRd;
      end
      chme_pkg::SHeadRd: begin
        head_re = 1'b1;
        state_d = chme_pkg::SHeadWait;
      end
      chme_pkg::SHeadWait: begin
        cur_d = head_rd;
        state_d = chme_pkg::SNodeWait;
      end
      chme_pkg::SNodeWait: begin
        if (!cur_ok || steps_q == IW'(NODES)) begin
          cur_d = LinkNull;
          state_d = chme_pkg::SCheck;
        end else begin
          state_d = chme_pkg::SCheck;
          steps_d = steps_q + 1'b1;
        end
      end
      chme_pkg::SCheck: begin
        if (cur_ok && key_rd == key_q) begin
          nlink_d = link_rd;
          unique case (cmd_q)
            chme_pkg::CmdInsert: state_d = chme_pkg::SOut;
            chme_pkg::CmdErase: begin
              st_d = chme_pkg::StDone;
              state_d = chme_pkg::SEraseWr;
            end
            chme_pkg::CmdLookup: begin
              st_d = chme_pkg::StDone;
              fv_d = val_rd;
              state_d = chme_pkg::SOut;
            end
            default: state_d = chme_pkg::SOut;
          endcase
        end else if (cur_ok) begin
          prev_d = cur_q;
          cur_d = link_rd;
          state_d = chme_pkg::SNodeWait;
        end else if (cmd_q == chme_pkg::CmdInsert) begin
          if (free_q >= LinkNull) begin
            st_d = chme_pkg::StFull;
            state_d = chme_pkg::SOut;
          end else begin
            cur_d = free_q;
            state_d = chme_pkg::SFreeWait;
          end
        end else begin
          state_d = chme_pkg::SOut;
        end
      end
      chme_pkg::SFreeWait: begin
        state_d = chme_pkg::SInsWr;
      end
      chme_pkg::SInsWr: begin
        free_d = link_rd;
        link_we = 1'b1;
        link_wd = headv_q;
        node_we = 1'b1;
        head_we = 1'b1;
        head_wd = cur_q;
        cnt_d = cnt_q + 1'b1;
        st_d = chme_pkg::StDone;
        state_d = chme_pkg::SOut;
      end
      chme_pkg::SEraseWr: begin
        link_we = 1'b1;
        link_wd = free_q;
        free_d = cur_q;
        if (cnt_q != '0) cnt_d = cnt_q - 1'b1;
        if (prev_q == LinkNull) begin
          head_we = 1'b1;
          head_wd = nlink_q;
          state_d = chme_pkg::SOut;
        end else begin
          state_d = chme_pkg::SEraseRd;
        end
      end
      chme_pkg::SEraseRd: begin
        link_we = 1'b1;
        link_a = prev_q[NW-1:0];
        link_wd = nlink_q;
        state_d = chme_pkg::SOut;
      end
      chme_pkg::SOut: begin
        ov_d = 1'b1;
        state_d = chme_pkg::SIdle;
      end
      default: state_d = chme_pkg::SIdle;
    endcase
  end

  assign out_valid_o   = ov_q;
  assign status_o      = st_q;
  assign found_value_o = fv_q;
  assign entry_count_o = cnt_q;

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 7'(NODES)) else $error("entry count above pool size");
  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (state_q == chme_pkg::SIdle && !ov_q)) else $error("ready while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !out_ready_i) |=> (ov_q && $stable(st_q) && $stable(fv_q)))
    else $error("result changed while stalled");
endmodule
`default_nettype wire
